FILE: rtl/touch_gyro_pointer_conditioner_assert.svh
// Assertion macros shared by the pointer conditioner RTL.
`ifndef TOUCH_GYRO_POINTER_CONDITIONER_ASSERT_SVH
`define TOUCH_GYRO_POINTER_CONDITIONER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tgpc_pkg.sv
// Types, widths and codes shared by the pointer conditioner RTL.
package tgpc_pkg;

    // Configuration port layout and register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_INTERVAL = 2'd3;

    // Field widths.
    localparam int TOUCH_W  = 16;
    localparam int RATE_W   = 16;
    localparam int ALPHA_W  = 9;
    localparam int BAND_W   = 15;
    localparam int TIME_W   = 32;
    localparam int MOTION_W = 12;
    localparam int EVENT_W  = 2;
    localparam int SCROLL_W = 2;

    // The smoothed rate never exceeds 2^27 in magnitude, so 29 signed bits hold it.
    localparam int SMOOTH_W = 29;

    // Fixed-point positions of the filter.
    localparam int FRAC_SHIFT   = 12;
    localparam int FILTER_SHIFT = 8;
    localparam int MOTION_SHIFT = 17;

    // Unity weight in Q1.8.
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    // Reset values of the configuration registers.
    localparam logic [TOUCH_W-1:0] THRESHOLD_RESET = 16'd50;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 9'd51;
    localparam logic [BAND_W-1:0]  BAND_RESET      = 15'd56;
    localparam logic [TOUCH_W-1:0] INTERVAL_RESET  = 16'd100;

    typedef logic signed [SMOOTH_W-1:0] smooth_t;
    typedef logic signed [MOTION_W-1:0] motion_t;
    typedef logic [EVENT_W-1:0]         event_t;
    typedef logic signed [SCROLL_W-1:0] scroll_t;

    // Button event codes.
    localparam event_t EVT_NONE    = 2'd0;
    localparam event_t EVT_PRESS   = 2'd1;
    localparam event_t EVT_RELEASE = 2'd2;

    // Scroll step codes.
    localparam scroll_t SCROLL_NONE = 2'sd0;
    localparam scroll_t SCROLL_UP   = 2'sd1;
    localparam scroll_t SCROLL_DOWN = -2'sd1;

    // Press on a rising touch, release on a falling one.
    function automatic event_t button_event(input logic touched, input logic was_touched);
        event_t ev;
        ev = EVT_NONE;
        if (touched && !was_touched)
        begin
            ev = EVT_PRESS;
        end
        else if (!touched && was_touched)
        begin
            ev = EVT_RELEASE;
        end
        return ev;
    endfunction

endpackage

FILE: rtl/tgpc_in_if.sv
// Input channel of the pointer conditioner: one sensor tick per beat.
interface tgpc_in_if;
    logic               valid;
    logic               ready;
    logic               connected;
    logic [31:0]        now_ms;
    logic [15:0]        activator_touch;
    logic [15:0]        left_touch;
    logic [15:0]        right_touch;
    logic [15:0]        up_touch;
    logic [15:0]        down_touch;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_z;

    modport source (
        output valid, connected, now_ms, activator_touch, left_touch, right_touch,
               up_touch, down_touch, rate_x, rate_z,
        input  ready
    );

    modport sink (
        input  valid, connected, now_ms, activator_touch, left_touch, right_touch,
               up_touch, down_touch, rate_x, rate_z,
        output ready
    );
endinterface

FILE: rtl/tgpc_out_if.sv
// Output channel of the pointer conditioner: one pointer report per beat.
interface tgpc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         left_event;
    logic [1:0]         right_event;
    logic               move_valid;
    logic signed [11:0] move_horiz;
    logic signed [11:0] move_vert;
    logic signed [1:0]  scroll_step;

    modport source (
        output valid, left_event, right_event, move_valid, move_horiz, move_vert,
               scroll_step,
        input  ready
    );

    modport sink (
        input  valid, left_event, right_event, move_valid, move_horiz, move_vert,
               scroll_step,
        output ready
    );
endinterface

FILE: rtl/tgpc_axis_filter.sv
// One axis of the exponential rate filter with its dead band and motion scaling.
module tgpc_axis_filter (
    input  logic signed [tgpc_pkg::RATE_W-1:0]  rate,
    input  logic        [tgpc_pkg::ALPHA_W-1:0] alpha,
    input  logic        [tgpc_pkg::BAND_W-1:0]  dead_band,
    input  tgpc_pkg::smooth_t                   smooth,
    output tgpc_pkg::smooth_t                   smooth_next,
    output tgpc_pkg::motion_t                   motion
);
    import tgpc_pkg::*;

    localparam int RATE_PROD_W = RATE_W + ALPHA_W + 1;
    localparam int HIST_PROD_W = SMOOTH_W + ALPHA_W + 1;
    localparam int SUM_W       = HIST_PROD_W + 2;
    localparam int BAND_FULL_W = BAND_W + FRAC_SHIFT;
    localparam smooth_t ROUND_BIAS = smooth_t'((1 << MOTION_SHIFT) - 1);

    logic               [ALPHA_W-1:0]     keep;
    logic signed        [RATE_PROD_W-1:0] rate_prod;
    logic signed        [HIST_PROD_W-1:0] hist_prod;
    logic signed        [SUM_W-1:0]       sum;
    logic               [SMOOTH_W-1:0]    mag;
    logic               [BAND_FULL_W-1:0] band_full;
    logic                                 outside_band;
    smooth_t                              biased;

    // Weighted sum of the new sample and the history, then a flooring shift.
    assign keep      = ALPHA_ONE - alpha;
    assign rate_prod = rate * $signed({1'b0, alpha});
    assign hist_prod = smooth * $signed({1'b0, keep});
    assign sum       = (SUM_W'(rate_prod) <<< FRAC_SHIFT) + SUM_W'(hist_prod);
    assign smooth_next = smooth_t'(sum >>> FILTER_SHIFT);

    // Dead band test on the magnitude of the new smoothed rate.
    assign mag          = smooth_next[SMOOTH_W-1] ? SMOOTH_W'(-smooth_next)
                                                  : SMOOTH_W'(smooth_next);
    assign band_full    = {dead_band, {FRAC_SHIFT{1'b0}}};
    assign outside_band = mag > SMOOTH_W'(band_full);

    // Half the rate in deg/s, truncated toward zero.
    assign biased = smooth_next + (smooth_next[SMOOTH_W-1] ? ROUND_BIAS : smooth_t'(0));
    assign motion = outside_band ? motion_t'(biased >>> MOTION_SHIFT) : motion_t'(0);

endmodule

FILE: rtl/touch_gyro_pointer_conditioner.sv
// Top level of the touch and gyro pointer conditioner.
// Each sensor tick beat is registered, processed combinationally against the filter
// and button state, and the pointer report lands in an output register; a tick with the
// link down updates nothing and gives no report. The block takes one tick per cycle
// while the report is not stalled, passing it through the input register and then the
// output register. When the report is stalled the input register still takes one
// further tick before ready falls. Configuration is written through a plain write port;
// the user must write it only while the block is idle, which the block does not enforce.
`include "touch_gyro_pointer_conditioner_assert.svh"

module touch_gyro_pointer_conditioner (
    input  logic                             clk,
    input  logic                             rst_n,
    tgpc_in_if.sink                          sample,
    tgpc_out_if.source                       report,
    input  logic                             cfg_we,
    input  logic [tgpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tgpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tgpc_pkg::*;

    // Configuration registers.
    logic [TOUCH_W-1:0] threshold_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [BAND_W-1:0]  band_reg;
    logic [TOUCH_W-1:0] interval_reg;

    // Input register.
    logic                     in_valid_reg;
    logic                     connected_reg;
    logic [TIME_W-1:0]        now_reg;
    logic [TOUCH_W-1:0]       act_touch_reg;
    logic [TOUCH_W-1:0]       left_touch_reg;
    logic [TOUCH_W-1:0]       right_touch_reg;
    logic [TOUCH_W-1:0]       up_touch_reg;
    logic [TOUCH_W-1:0]       down_touch_reg;
    logic signed [RATE_W-1:0] rate_x_reg;
    logic signed [RATE_W-1:0] rate_z_reg;

    // Tick-to-tick state.
    smooth_t           smooth_x_reg;
    smooth_t           smooth_z_reg;
    smooth_t           smooth_x_next;
    smooth_t           smooth_z_next;
    logic              left_was_reg;
    logic              right_was_reg;
    logic [TIME_W-1:0] last_scroll_reg;
    logic [TIME_W-1:0] last_scroll_next;

    // Output register.
    logic    out_valid_reg;
    logic    out_valid_next;
    event_t  left_event_reg;
    event_t  right_event_reg;
    logic    move_valid_reg;
    motion_t move_horiz_reg;
    motion_t move_vert_reg;
    scroll_t scroll_step_reg;

    // Datapath signals.
    logic               advance;
    logic               stage_fire;
    logic               in_beat;
    logic [ALPHA_W-1:0] alpha_eff;
    logic               act_touched;
    logic               left_touched;
    logic               right_touched;
    logic               scroll_due;
    smooth_t            filt_x;
    smooth_t            filt_z;
    motion_t            motion_x;
    motion_t            motion_z;
    motion_t            horiz;
    motion_t            vert;
    scroll_t            scroll;
    logic               move_any;

    // Configuration writes; an index beyond the list never occurs with this index width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            alpha_reg     <= ALPHA_RESET;
            band_reg      <= BAND_RESET;
            interval_reg  <= INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOUCH_THRESHOLD: threshold_reg <= cfg_data[TOUCH_W-1:0];
                CFG_FILTER_ALPHA:    alpha_reg     <= cfg_data[ALPHA_W-1:0];
                CFG_DEAD_BAND:       band_reg      <= cfg_data[BAND_W-1:0];
                CFG_SCROLL_INTERVAL: interval_reg  <= cfg_data[TOUCH_W-1:0];
                default:             threshold_reg <= threshold_reg;
            endcase
        end
    end

    // Handshake: the stage moves when the output register is free or being emptied.
    assign advance      = !out_valid_reg || report.ready;
    assign sample.ready = !in_valid_reg || advance;
    assign in_beat      = sample.valid && sample.ready;
    assign stage_fire   = in_valid_reg && advance && connected_reg;

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            connected_reg   <= sample.connected;
            now_reg         <= sample.now_ms;
            act_touch_reg   <= sample.activator_touch;
            left_touch_reg  <= sample.left_touch;
            right_touch_reg <= sample.right_touch;
            up_touch_reg    <= sample.up_touch;
            down_touch_reg  <= sample.down_touch;
            rate_x_reg      <= sample.rate_x;
            rate_z_reg      <= sample.rate_z;
        end
    end

    // Touch decisions and the clamped filter weight.
    assign alpha_eff     = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign act_touched   = act_touch_reg < threshold_reg;
    assign left_touched  = left_touch_reg < threshold_reg;
    assign right_touched = right_touch_reg < threshold_reg;

    // Two independent axis filters.
    tgpc_axis_filter u_filter_x (
        .rate        (rate_x_reg),
        .alpha       (alpha_eff),
        .dead_band   (band_reg),
        .smooth      (smooth_x_reg),
        .smooth_next (filt_x),
        .motion      (motion_x)
    );

    tgpc_axis_filter u_filter_z (
        .rate        (rate_z_reg),
        .alpha       (alpha_eff),
        .dead_band   (band_reg),
        .smooth      (smooth_z_reg),
        .smooth_next (filt_z),
        .motion      (motion_z)
    );

    // Filters run only while the activator is held; otherwise they clear.
    always_comb
    begin
        smooth_x_next = act_touched ? filt_x : smooth_t'(0);
        smooth_z_next = act_touched ? filt_z : smooth_t'(0);
        horiz         = act_touched ? motion_z : motion_t'(0);
        vert          = act_touched ? motion_x : motion_t'(0);
    end

    // Scroll sampling, with up taking priority over down.
    always_comb
    begin
        scroll_due       = (now_reg - last_scroll_reg) > TIME_W'(interval_reg);
        scroll           = SCROLL_NONE;
        last_scroll_next = last_scroll_reg;
        if (scroll_due)
        begin
            last_scroll_next = now_reg;
            if (up_touch_reg < threshold_reg)
            begin
                scroll = SCROLL_UP;
            end
            else if (down_touch_reg < threshold_reg)
            begin
                scroll = SCROLL_DOWN;
            end
        end
        move_any       = (horiz != motion_t'(0)) || (vert != motion_t'(0))
                         || (scroll != SCROLL_NONE);
        out_valid_next = advance ? (in_valid_reg && connected_reg) : out_valid_reg;
    end

    // State update, once per connected tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_x_reg    <= smooth_t'(0);
            smooth_z_reg    <= smooth_t'(0);
            left_was_reg    <= 1'b0;
            right_was_reg   <= 1'b0;
            last_scroll_reg <= '0;
        end
        else if (stage_fire)
        begin
            smooth_x_reg    <= smooth_x_next;
            smooth_z_reg    <= smooth_z_next;
            left_was_reg    <= left_touched;
            right_was_reg   <= right_touched;
            last_scroll_reg <= last_scroll_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register payload; motion and scroll are zero when nothing is reported.
    always_ff @(posedge clk)
    begin
        if (stage_fire)
        begin
            left_event_reg  <= button_event(left_touched, left_was_reg);
            right_event_reg <= button_event(right_touched, right_was_reg);
            move_valid_reg  <= move_any;
            move_horiz_reg  <= horiz;
            move_vert_reg   <= vert;
            scroll_step_reg <= scroll;
        end
    end

    assign report.valid       = out_valid_reg;
    assign report.left_event  = left_event_reg;
    assign report.right_event = right_event_reg;
    assign report.move_valid  = move_valid_reg;
    assign report.move_horiz  = move_horiz_reg;
    assign report.move_vert   = move_vert_reg;
    assign report.scroll_step = scroll_step_reg;

    // A report without motion carries no motion or scroll.
    `TGPC_ASSERT_NOW(a_quiet_report, report.valid && !report.move_valid,
        report.move_horiz == 12'sd0 && report.move_vert == 12'sd0
            && report.scroll_step == SCROLL_NONE,
        "report without motion has nonzero fields")

    // Releasing the activator clears both filters.
    `TGPC_ASSERT_NEXT(a_filter_clear, stage_fire && !act_touched,
        smooth_x_reg == smooth_t'(0) && smooth_z_reg == smooth_t'(0),
        "filters not cleared on activator release")

    // A scroll sample records the tick's timestamp.
    `TGPC_ASSERT_NEXT(a_scroll_stamp, stage_fire && scroll_due,
        last_scroll_reg == $past(now_reg), "scroll timestamp not taken")

endmodule
